>>> rtl/arpslt_pkg.sv
// Shared types and constants for the ARP sender learning table.
// No dependencies; used by arp_sender_learning_table through scoped names.
`default_nettype none

package arpslt_pkg;

  // Result status codes
  localparam logic [3:0] ST_STORED    = 4'd0;
  localparam logic [3:0] ST_SHORT     = 4'd1;
  localparam logic [3:0] ST_NOT_ARP   = 4'd2;
  localparam logic [3:0] ST_BAD_OP    = 4'd3;
  localparam logic [3:0] ST_BAD_FMT   = 4'd4;
  localparam logic [3:0] ST_FULL      = 4'd5;
  localparam logic [3:0] ST_NETWORK   = 4'd6;
  localparam logic [3:0] ST_BROADCAST = 4'd7;
  localparam logic [3:0] ST_SELF      = 4'd8;
  localparam logic [3:0] ST_DUPLICATE = 4'd9;

  // Configuration register indexes
  localparam logic [1:0] CFG_OWN_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_HOST_MASK   = 2'd1;
  localparam logic [1:0] CFG_TABLE_LIMIT = 2'd2;

  // Frame format constants
  localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
  localparam logic [15:0] ARP_OP_REQ    = 16'h0001;
  localparam logic [15:0] ARP_OP_REPLY  = 16'h0002;
  localparam logic [15:0] HW_ETHERNET   = 16'h0001;
  localparam logic [15:0] ADDR_LENGTHS  = 16'h0604;
  localparam logic [5:0]  POS_MAX       = 6'd63;
  // Last byte sits at this position or beyond for a frame of 42 bytes or more
  localparam logic [5:0]  POS_LAST_MIN  = 6'd41;

  // One stored neighbor
  typedef struct packed {
    logic [47:0] mac;
    logic [31:0] ip;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/arp_sender_learning_table.sv
// Throughput: frame bytes are taken one per cycle while in S_RX. After the last byte
// the input stalls for a check state, a table scan (one memory read a cycle, cut
// short on a match; skipped when a check fails) and an emit state, which also
// waits for out_tready when a result is still pending.
// Reset (rst_n low, synchronous) clears control, counters and config; the table
// memory is not cleared, only entries below the count are ever read.
// ARP sender learning table, top level. Uses arpslt_pkg.
`default_nettype none

module arp_sender_learning_table #(
  parameter int TABLE_DEPTH = 32
) (
  input  wire         clk,
  input  wire         rst_n,
  // Frame byte stream
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] frame_byte
  input  wire         in_tlast,   // last_byte
  // Result stream
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [95:0] out_tdata,  // [3:0] status, [35:4] src_ip,
                                  // [83:36] src_mac, [89:84] entry_count
  // Configuration writes
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [31:0] cfg_data
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int EXT_W = (CNT_W > 6) ? CNT_W : 6;

  localparam logic [1:0] S_RX    = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]  state_r, state_nxt;

  // Configuration registers
  logic [31:0] own_r, mask_r;
  logic [5:0]  limit_r;

  // Frame capture
  logic [5:0]  pos_r;
  logic        short_r;
  logic [15:0] ether_r, hw_r, lens_r, op_r;
  logic [47:0] mac_r;
  logic [31:0] ip_r;

  // Table control
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic             cmp_valid_r, cmp_valid_nxt;
  logic [3:0]       status_r, status_nxt;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [95:0] out_data_r;

  // Memory ports
  arpslt_pkg::entry_t mem [TABLE_DEPTH];
  arpslt_pkg::entry_t rd_data_r;
  logic               rd_en, wr_en;

  logic        in_xfer, emit, store, full, hit, reject;
  logic [3:0]  check_status;
  logic [EXT_W-1:0] count_ext;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_RX);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration writes; an index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r   <= 32'd0;
      mask_r  <= 32'd255;
      limit_r <= 6'd32;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        arpslt_pkg::CFG_OWN_ADDRESS: own_r   <= cfg_data;
        arpslt_pkg::CFG_HOST_MASK:   mask_r  <= cfg_data;
        arpslt_pkg::CFG_TABLE_LIMIT: limit_r <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Byte position and header capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 6'd0;
      short_r <= 1'b1;
      ether_r <= 16'd0;
      hw_r    <= 16'd0;
      lens_r  <= 16'd0;
      op_r    <= 16'd0;
      mac_r   <= 48'd0;
      ip_r    <= 32'd0;
    end else if (in_xfer) begin
      case (pos_r) inside
        6'd12, 6'd13:   ether_r <= {ether_r[7:0], in_tdata};
        6'd14, 6'd15:   hw_r    <= {hw_r[7:0], in_tdata};
        6'd18, 6'd19:   lens_r  <= {lens_r[7:0], in_tdata};
        6'd20, 6'd21:   op_r    <= {op_r[7:0], in_tdata};
        [6'd22:6'd27]:  mac_r   <= {mac_r[39:0], in_tdata};
        [6'd28:6'd31]:  ip_r    <= {ip_r[23:0], in_tdata};
        default: ;
      endcase
      if (in_tlast) begin
        pos_r   <= 6'd0;
        short_r <= (pos_r < arpslt_pkg::POS_LAST_MIN);
      end else if (pos_r != arpslt_pkg::POS_MAX) begin
        pos_r <= pos_r + 6'd1;
      end
    end
  end

  // Frame and sender checks, in priority order
  assign full = (EXT_W'(count_r) >= EXT_W'(limit_r)) ||
                (count_r >= CNT_W'(TABLE_DEPTH));

  always_comb begin
    if (short_r)
      check_status = arpslt_pkg::ST_SHORT;
    else if (ether_r != arpslt_pkg::ETHERTYPE_ARP)
      check_status = arpslt_pkg::ST_NOT_ARP;
    else if (op_r != arpslt_pkg::ARP_OP_REQ && op_r != arpslt_pkg::ARP_OP_REPLY)
      check_status = arpslt_pkg::ST_BAD_OP;
    else if (lens_r != arpslt_pkg::ADDR_LENGTHS || hw_r != arpslt_pkg::HW_ETHERNET)
      check_status = arpslt_pkg::ST_BAD_FMT;
    else if (full)
      check_status = arpslt_pkg::ST_FULL;
    else if ((ip_r & mask_r) == 32'd0)
      check_status = arpslt_pkg::ST_NETWORK;
    else if ((ip_r | mask_r) == 32'hffff_ffff)
      check_status = arpslt_pkg::ST_BROADCAST;
    else if (ip_r == own_r)
      check_status = arpslt_pkg::ST_SELF;
    else
      check_status = arpslt_pkg::ST_STORED;
  end

  // Scan compare: read data belongs to the address issued last cycle
  assign hit   = cmp_valid_r && (rd_data_r.ip == ip_r);
  assign rd_en = (state_r == S_SCAN) && (ptr_r < count_r) && !hit;
  assign emit  = (state_r == S_EMIT) && (!out_valid_r || out_tready);
  assign store = (status_r == arpslt_pkg::ST_STORED);
  assign wr_en = emit && store;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    status_nxt    = status_r;
    ptr_nxt       = ptr_r;
    cmp_valid_nxt = 1'b0;
    count_nxt     = count_r;
    unique case (state_r)
      S_RX: begin
        if (in_xfer && in_tlast) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        status_nxt = check_status;
        ptr_nxt    = '0;
        state_nxt  = (check_status == arpslt_pkg::ST_STORED) ? S_SCAN : S_EMIT;
      end
      S_SCAN: begin
        if (hit) begin
          status_nxt = arpslt_pkg::ST_DUPLICATE;
          state_nxt  = S_EMIT;
        end else if (rd_en) begin
          ptr_nxt       = ptr_r + CNT_W'(1);
          cmp_valid_nxt = 1'b1;
        end else begin
          // all filled entries compared without a match
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit) begin
          state_nxt = S_RX;
          if (store) count_nxt = count_r + CNT_W'(1);
        end
      end
      default: state_nxt = S_RX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RX;
      status_r    <= arpslt_pkg::ST_STORED;
      ptr_r       <= '0;
      cmp_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      ptr_r       <= ptr_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[count_r[AW-1:0]] <= '{mac: mac_r, ip: ip_r};
    if (rd_en) rd_data_r <= mem[ptr_r[AW-1:0]];
  end

  // Result register
  assign reject = (status_r == arpslt_pkg::ST_SHORT)   ||
                  (status_r == arpslt_pkg::ST_NOT_ARP) ||
                  (status_r == arpslt_pkg::ST_BAD_OP)  ||
                  (status_r == arpslt_pkg::ST_BAD_FMT);
  assign count_ext = EXT_W'(count_nxt);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {6'd0, count_ext[5:0],
                     reject ? 48'd0 : mac_r,
                     reject ? 32'd0 : ip_r,
                     status_r};
    end
  end

  // Table count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("table count beyond depth");

  // Count moves only by one, and only when a stored result goes out
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("table count did not advance on store");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !wr_en |=> $stable(count_r))
    else $error("table count changed without store");

  // Scan reads stay within filled entries
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> ptr_r < count_r)
    else $error("scan read past filled entries");

  // A pending result is never overwritten by a new one
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !emit)
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

>>> tb/sv/arp_sender_learning_table_tb.sv
// Self-checking testbench for arp_sender_learning_table: byte-stream frames in,
// learning verdicts out, checked against an in-bench prediction of the table.
// Depends on arpslt_pkg (status codes, register indexes, ARP constants) and the RTL.

module arp_sender_learning_table_tb;

  localparam int TABLE_DEPTH = 32;
  localparam int FRAME_MIN   = 42;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } wire_byte_t;

  typedef struct {
    logic [3:0]  status;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [5:0]  count;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] frame_byte
  logic        in_tlast = 1'b0; // last_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [95:0] out_tdata;       // [3:0] status, [35:4] src_ip,
                                // [83:36] src_mac, [89:84] entry_count
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  arp_sender_learning_table #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bytes waiting to be sent and verdicts waiting to come back
  wire_byte_t frame_bytes[$];
  verdict_t   expected_verdicts[$];
  int         fails = 0;
  int         bytes_queued = 0;
  int         frames_queued = 0;

  // Shadow registers
  logic [31:0] my_ip = 32'd0;
  logic [31:0] host_bits = 32'd255;
  logic [5:0]  entry_cap = 6'd32;

  // Shadow parser and table
  logic [5:0]  byte_idx = '0;
  logic [15:0] eth_type = '0;
  logic [15:0] hw_type = '0;
  logic [15:0] len_pair = '0;
  logic [15:0] opcode = '0;
  logic [47:0] src_mac_cap = '0;
  logic [31:0] src_ip_cap = '0;
  logic [31:0] known_ips [TABLE_DEPTH];
  logic [5:0]  known_count = '0;

  // Verdict on a completed frame; appends the sender when it passes every filter
  function automatic logic [3:0] judge_frame();
    if (byte_idx < FRAME_MIN) return arpslt_pkg::ST_SHORT;
    if (eth_type != arpslt_pkg::ETHERTYPE_ARP) return arpslt_pkg::ST_NOT_ARP;
    if (opcode != arpslt_pkg::ARP_OP_REQ && opcode != arpslt_pkg::ARP_OP_REPLY)
      return arpslt_pkg::ST_BAD_OP;
    if (len_pair != arpslt_pkg::ADDR_LENGTHS || hw_type != arpslt_pkg::HW_ETHERNET)
      return arpslt_pkg::ST_BAD_FMT;
    if (known_count >= entry_cap || known_count >= TABLE_DEPTH) return arpslt_pkg::ST_FULL;
    if ((src_ip_cap & host_bits) == 32'd0) return arpslt_pkg::ST_NETWORK;
    if ((src_ip_cap | host_bits) == 32'hFFFF_FFFF) return arpslt_pkg::ST_BROADCAST;
    if (src_ip_cap == my_ip) return arpslt_pkg::ST_SELF;
    for (int k = 0; k < known_count; k++)
      if (known_ips[k] == src_ip_cap) return arpslt_pkg::ST_DUPLICATE;
    known_ips[known_count] = src_ip_cap;
    known_count = known_count + 6'd1;
    return arpslt_pkg::ST_STORED;
  endfunction

  // Advance the shadow parser by one accepted byte
  task automatic learn_byte(input logic [7:0] b, input logic last);
    verdict_t v;
    if (byte_idx < FRAME_MIN) begin
      case (byte_idx)
        6'd12, 6'd13: eth_type = {eth_type[7:0], b};
        6'd14, 6'd15: hw_type = {hw_type[7:0], b};
        6'd18, 6'd19: len_pair = {len_pair[7:0], b};
        6'd20, 6'd21: opcode = {opcode[7:0], b};
        default: begin
          if (byte_idx >= 22 && byte_idx <= 27)
            src_mac_cap = {src_mac_cap[39:0], b};
          else if (byte_idx >= 28 && byte_idx <= 31)
            src_ip_cap = {src_ip_cap[23:0], b};
        end
      endcase
    end
    if (byte_idx < arpslt_pkg::POS_MAX) byte_idx = byte_idx + 6'd1;
    if (last) begin
      v.status = judge_frame();
      // rejected frames report zero addresses
      if (v.status >= arpslt_pkg::ST_SHORT && v.status <= arpslt_pkg::ST_BAD_FMT) begin
        v.ip = '0;
        v.mac = '0;
      end else begin
        v.ip = src_ip_cap;
        v.mac = src_mac_cap;
      end
      v.count = known_count;
      byte_idx = '0;
      expected_verdicts.push_back(v);
    end
  endtask

  // Byte driver: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : drive_bytes
    wire_byte_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tlast <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) learn_byte(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (frame_bytes.size() > 0) begin
          nxt = frame_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= nxt.data;
          in_tlast <= nxt.last;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: stall style and mask change each time the 8-bit phase counter wraps
  logic [7:0]  ready_phase = '0;
  logic [1:0]  ready_style = '0;
  logic [15:0] ready_mask = 16'hFFFF;

  always @(posedge clk) begin
    if (!rst_n) begin
      ready_phase <= '0;
      ready_style <= '0;
      ready_mask <= 16'hFFFF;
      out_tready <= 1'b0;
    end else begin
      ready_phase <= ready_phase + 8'd1;
      if (ready_phase == 8'hFF) begin
        ready_style <= 2'($urandom_range(0, 3));
        ready_mask <= 16'($urandom);
      end
      case (ready_style)
        2'd0: out_tready <= 1'b1;
        2'd1: out_tready <= ready_mask[ready_phase[3:0]];
        default: out_tready <= ready_mask[ready_phase[7:4]];
      endcase
    end
  end

  // Result monitor: each transfer against the oldest predicted verdict
  always @(posedge clk) begin : check_verdicts
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d", $time,
                 out_tdata[3:0]);
        fails++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_tdata[3:0] !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_tdata[3:0]);
          fails++;
        end
        if (out_tdata[35:4] !== want.ip) begin
          $display("%0t: src_ip expected %h actual %h", $time, want.ip,
                   out_tdata[35:4]);
          fails++;
        end
        if (out_tdata[83:36] !== want.mac) begin
          $display("%0t: src_mac expected %h actual %h", $time, want.mac,
                   out_tdata[83:36]);
          fails++;
        end
        if (out_tdata[89:84] !== want.count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.count,
                   out_tdata[89:84]);
          fails++;
        end
      end
    end
  end

  // Register write; only issued while the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      arpslt_pkg::CFG_OWN_ADDRESS: my_ip = val;
      arpslt_pkg::CFG_HOST_MASK:   host_bits = val;
      arpslt_pkg::CFG_TABLE_LIMIT: entry_cap = val[5:0];
      default: ;
    endcase
  endtask

  // Wait for all bytes and verdicts, then for the scan latency
  task automatic drain();
    while (frame_bytes.size() != 0 || in_tvalid || expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);
  endtask

  task automatic push_frame(input int len, input logic [15:0] etype, input logic [15:0] hw,
                            input logic [15:0] lens, input logic [15:0] op,
                            input logic [47:0] mac, input logic [31:0] ip);
    logic [7:0] hdr [32];
    wire_byte_t wb;
    for (int i = 0; i < 32; i++) hdr[i] = 8'($urandom);
    {hdr[12], hdr[13]} = etype;
    {hdr[14], hdr[15]} = hw;
    {hdr[18], hdr[19]} = lens;
    {hdr[20], hdr[21]} = op;
    {hdr[22], hdr[23], hdr[24], hdr[25], hdr[26], hdr[27]} = mac;
    {hdr[28], hdr[29], hdr[30], hdr[31]} = ip;
    for (int i = 0; i < len; i++) begin
      wb.data = (i < 32) ? hdr[i] : 8'($urandom);
      wb.last = (i == len - 1);
      frame_bytes.push_back(wb);
    end
    bytes_queued += len;
    frames_queued++;
  endtask

  task automatic push_arp(input int len, input logic [15:0] op, input logic [47:0] mac,
                          input logic [31:0] ip);
    push_frame(len, arpslt_pkg::ETHERTYPE_ARP, arpslt_pkg::HW_ETHERNET,
               arpslt_pkg::ADDR_LENGTHS, op, mac, ip);
  endtask

  function automatic logic [47:0] rand_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Sender address: fresh, from a small pool in our subnet, or a filtered corner
  function automatic logic [31:0] pick_src_ip();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom;
    if (r < 80) return (my_ip & ~host_bits) | (32'($urandom_range(1, 12)) & host_bits);
    if (r < 87) return $urandom & ~host_bits;
    if (r < 94) return $urandom | host_bits;
    return my_ip;
  endfunction

  task automatic push_random_frame();
    int pick;
    int len;
    logic [15:0] op;
    pick = $urandom_range(0, 99);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(43, 90) : $urandom_range(42, 50);
    op = $urandom_range(0, 1) ? arpslt_pkg::ARP_OP_REQ : arpslt_pkg::ARP_OP_REPLY;
    if (pick < 72)
      push_arp(len, op, rand_mac(), pick_src_ip());
    else if (pick < 76)
      push_frame(len, 16'($urandom), arpslt_pkg::HW_ETHERNET, arpslt_pkg::ADDR_LENGTHS, op,
                 rand_mac(), pick_src_ip());
    else if (pick < 79)
      push_frame(len, arpslt_pkg::ETHERTYPE_ARP, arpslt_pkg::HW_ETHERNET,
                 arpslt_pkg::ADDR_LENGTHS, 16'($urandom), rand_mac(), pick_src_ip());
    else if (pick < 82)
      push_frame(len, arpslt_pkg::ETHERTYPE_ARP, 16'($urandom), arpslt_pkg::ADDR_LENGTHS,
                 op, rand_mac(), pick_src_ip());
    else if (pick < 85)
      push_frame(len, arpslt_pkg::ETHERTYPE_ARP, arpslt_pkg::HW_ETHERNET, 16'($urandom),
                 op, rand_mac(), pick_src_ip());
    else if (pick < 95)
      push_arp($urandom_range(1, FRAME_MIN - 1), op, rand_mac(), pick_src_ip());
    else
      push_frame($urandom_range(1, 90), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), rand_mac(), $urandom);
  endtask

  task automatic random_traffic(input int min_bytes, input int min_frames);
    int b0;
    int f0;
    b0 = bytes_queued;
    f0 = frames_queued;
    while (bytes_queued - b0 < min_bytes || frames_queued - f0 < min_frames)
      push_random_frame();
    drain();
  endtask

  // Stimulus sequence
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every status but full, field extremes, short and long frames
    write_reg(arpslt_pkg::CFG_OWN_ADDRESS, 32'hC0A8_0105);
    write_reg(arpslt_pkg::CFG_HOST_MASK, 32'h0000_00FF);
    write_reg(arpslt_pkg::CFG_TABLE_LIMIT, 32'd32);
    push_arp(FRAME_MIN, arpslt_pkg::ARP_OP_REQ, 48'h0, 32'hC0A8_0111);
    push_arp(FRAME_MIN, arpslt_pkg::ARP_OP_REPLY, 48'hFFFF_FFFF_FFFF, 32'hC0A8_0111);
    push_arp(FRAME_MIN - 1, arpslt_pkg::ARP_OP_REQ, rand_mac(), 32'hC0A8_0122);
    push_arp(1, arpslt_pkg::ARP_OP_REQ, rand_mac(), 32'hC0A8_0122);
    push_arp(1, arpslt_pkg::ARP_OP_REQ, rand_mac(), 32'hC0A8_0122);
    push_frame(FRAME_MIN, 16'h0800, arpslt_pkg::HW_ETHERNET, arpslt_pkg::ADDR_LENGTHS,
               arpslt_pkg::ARP_OP_REQ, rand_mac(), 32'hC0A8_0123);
    push_frame(FRAME_MIN, arpslt_pkg::ETHERTYPE_ARP, arpslt_pkg::HW_ETHERNET,
               arpslt_pkg::ADDR_LENGTHS, 16'h0000, rand_mac(), 32'hC0A8_0123);
    push_frame(FRAME_MIN, arpslt_pkg::ETHERTYPE_ARP, arpslt_pkg::HW_ETHERNET,
               arpslt_pkg::ADDR_LENGTHS, 16'hFFFF, rand_mac(), 32'hC0A8_0123);
    push_frame(FRAME_MIN, arpslt_pkg::ETHERTYPE_ARP, 16'h0002, arpslt_pkg::ADDR_LENGTHS,
               arpslt_pkg::ARP_OP_REQ, rand_mac(), 32'hC0A8_0123);
    push_frame(FRAME_MIN, arpslt_pkg::ETHERTYPE_ARP, arpslt_pkg::HW_ETHERNET, 16'h0605,
               arpslt_pkg::ARP_OP_REQ, rand_mac(), 32'hC0A8_0123);
    push_frame(FRAME_MIN, arpslt_pkg::ETHERTYPE_ARP, arpslt_pkg::HW_ETHERNET, 16'h0704,
               arpslt_pkg::ARP_OP_REQ, rand_mac(), 32'hC0A8_0123);
    push_arp(FRAME_MIN, arpslt_pkg::ARP_OP_REQ, rand_mac(), 32'hC0A8_0100);
    push_arp(FRAME_MIN, arpslt_pkg::ARP_OP_REQ, rand_mac(), 32'hC0A8_01FF);
    push_arp(FRAME_MIN, arpslt_pkg::ARP_OP_REPLY, rand_mac(), 32'hC0A8_0105);
    push_arp(90, arpslt_pkg::ARP_OP_REPLY, rand_mac(), 32'hC0A8_0133);
    push_arp(64, arpslt_pkg::ARP_OP_REQ, rand_mac(), 32'hC0A8_0134);
    drain();

    // Zero limit: any valid sender is refused as full
    write_reg(arpslt_pkg::CFG_TABLE_LIMIT, 32'd0);
    push_arp(FRAME_MIN, arpslt_pkg::ARP_OP_REQ, rand_mac(), 32'hC0A8_0144);
    drain();

    // Mask extremes; upper data bits of the limit write are ignored
    write_reg(arpslt_pkg::CFG_TABLE_LIMIT, 32'hFFFF_FFE0);
    write_reg(arpslt_pkg::CFG_HOST_MASK, 32'h0000_0000);
    push_arp(FRAME_MIN, arpslt_pkg::ARP_OP_REQ, rand_mac(), 32'hC0A8_0155);
    drain();
    write_reg(arpslt_pkg::CFG_HOST_MASK, 32'hFFFF_FFFF);
    write_reg(arpslt_pkg::CFG_OWN_ADDRESS, 32'hFFFF_FFFF);
    push_arp(FRAME_MIN, arpslt_pkg::ARP_OP_REQ, rand_mac(), 32'h0000_0000);
    push_arp(FRAME_MIN, arpslt_pkg::ARP_OP_REQ, rand_mac(), 32'h1234_5678);
    drain();
    write_reg(arpslt_pkg::CFG_OWN_ADDRESS, 32'h0000_0000);
    push_arp(FRAME_MIN, arpslt_pkg::ARP_OP_REQ, rand_mac(), 32'hFFFF_FFFF);
    drain();

    // Random traffic under several settings; the low limit of the second one
    // refuses valid senders as full
    write_reg(arpslt_pkg::CFG_OWN_ADDRESS, 32'h0A00_0007);
    write_reg(arpslt_pkg::CFG_HOST_MASK, 32'h0000_00FF);
    write_reg(arpslt_pkg::CFG_TABLE_LIMIT, 32'hFFFF_FFC8);
    random_traffic(80, 2);
    write_reg(arpslt_pkg::CFG_OWN_ADDRESS, {16'hAC10, 16'($urandom)});
    write_reg(arpslt_pkg::CFG_HOST_MASK, 32'h0000_FFFF);
    write_reg(arpslt_pkg::CFG_TABLE_LIMIT, 32'd5);
    random_traffic(80, 2);
    write_reg(arpslt_pkg::CFG_OWN_ADDRESS, 32'h0A00_0007);
    write_reg(arpslt_pkg::CFG_HOST_MASK, 32'h0000_00FF);
    write_reg(arpslt_pkg::CFG_TABLE_LIMIT, 32'd63);
    random_traffic(80, 2);

    if (fails == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
